// ===== rtl/frwc_pkg.sv =====
// Shared constants, command codes and status types for the float range width classifier.
package frwc_pkg;

    localparam int unsigned FRAC_BITS = 23;
    localparam int unsigned EXP_BITS  = 8;

    localparam logic [22:0] FRAC_MASK = 23'h7FFFFF;
    localparam logic [7:0]  EXP_NAN   = 8'hFF;
    localparam logic [23:0] FRAC_ONE  = 24'h800000;
    localparam logic [63:0] LIMIT32   = 64'd512;
    localparam logic [63:0] LIMIT64   = 64'd2199023255552;

    localparam logic [1:0] ST_U32   = 2'd0;
    localparam logic [1:0] ST_U64   = 2'd1;
    localparam logic [1:0] ST_LONG  = 2'd2;
    localparam logic [1:0] ST_ORDER = 2'd3;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_INIT_SS,
        CMD_INIT_A,
        CMD_INIT_B,
        CMD_STEP,
        CMD_ACC_LO,
        CMD_ACC_HI,
        CMD_ACC_EQ,
        CMD_ACC_TAIL,
        CMD_ROUND,
        CMD_CLASS,
        CMD_LONG,
        CMD_ORDER
    } t_cmd;

    typedef struct packed {
        logic order;
        logic mixed;
        logic exp_eq;
        logic loop_done;
        logic ovf;
    } t_dp_stat;

endpackage

// ===== rtl/frwc_datapath.sv =====
// Datapath: operand fields, group accumulator, weight shift count and loop counter.
module frwc_datapath (
    input  logic                i_clk,
    input  frwc_pkg::t_cmd      i_cmd,
    input  logic [31:0]         i_min_bits,
    input  logic [31:0]         i_max_bits,
    output frwc_pkg::t_dp_stat  o_stat,
    output logic [1:0]          o_status
);

    function automatic logic is_nan(input logic [31:0] x);
        return (x[30:23] == frwc_pkg::EXP_NAN) && (x[22:0] != 23'd0);
    endfunction

    function automatic logic [31:0] order_key(input logic [31:0] x);
        return x[31] ? ~x : {1'b1, x[30:0]};
    endfunction

    logic [7:0]  r_lo_exp;
    logic [7:0]  r_hi_exp;
    logic [22:0] r_lo_frac;
    logic [22:0] r_hi_frac;
    logic        r_mixed;
    logic        r_order;
    logic [63:0] r_groups;
    logic [22:0] r_rem;
    logic [8:0]  r_idx;
    logic [7:0]  r_tgt;
    logic [5:0]  r_sh;
    logic        r_ss;
    logic [1:0]  r_status;

    logic        in_mixed;
    logic        in_swap;
    logic        in_order;
    logic        dbl;
    logic [5:0]  sh_lo;
    logic [5:0]  sh_hi;
    logic [63:0] prod_lo;
    logic [63:0] prod_hi;
    logic [31:0] eq_diff;
    logic [63:0] addend;
    logic [23:0] low_sum;
    logic [63:0] acc_groups;

    assign in_mixed = i_min_bits[31] != i_max_bits[31];
    assign in_swap  = !in_mixed && i_min_bits[31];
    assign in_order = !is_nan(i_min_bits) && !is_nan(i_max_bits)
                      && ((i_min_bits[30:0] | i_max_bits[30:0]) != 31'd0)
                      && (order_key(i_min_bits) > order_key(i_max_bits));

    assign dbl   = r_ss || (r_idx != 9'd0);
    assign sh_lo = (r_lo_exp == frwc_pkg::EXP_NAN) ? 6'd0 : r_sh;
    assign sh_hi = (r_hi_exp == frwc_pkg::EXP_NAN) ? 6'd0 : r_sh;

    assign prod_lo = {40'd0, {1'b0, r_lo_frac} + 24'd1} << sh_lo;
    assign prod_hi = {40'd0, {1'b0, r_hi_frac} + 24'd1} << sh_hi;
    assign eq_diff = {9'd0, r_hi_frac} - {9'd0, r_lo_frac} + 32'd1;

    always_comb begin
        unique case (i_cmd)
            frwc_pkg::CMD_ACC_LO: addend = prod_lo;
            frwc_pkg::CMD_ACC_HI: addend = prod_hi;
            frwc_pkg::CMD_ACC_EQ: addend = {32'd0, eq_diff};
            default:              addend = {40'd0, frwc_pkg::FRAC_ONE - {1'b0, r_lo_frac}};
        endcase
    end

    assign low_sum    = {1'b0, r_rem} + {1'b0, addend[22:0]};
    assign acc_groups = r_groups + {23'd0, addend[63:23]} + {63'd0, low_sum[23]};

    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            frwc_pkg::CMD_LOAD: begin
                r_lo_exp  <= in_swap ? i_max_bits[30:23] : i_min_bits[30:23];
                r_hi_exp  <= in_swap ? i_min_bits[30:23] : i_max_bits[30:23];
                r_lo_frac <= in_swap ? i_max_bits[22:0] : i_min_bits[22:0];
                r_hi_frac <= in_swap ? i_min_bits[22:0] : i_max_bits[22:0];
                r_mixed   <= in_mixed;
                r_order   <= in_order;
                r_groups  <= 64'd0;
                r_rem     <= 23'd0;
            end
            frwc_pkg::CMD_INIT_SS: begin
                r_ss  <= 1'b1;
                r_tgt <= r_hi_exp;
                r_idx <= {1'b0, r_lo_exp} + 9'd1;
                r_sh  <= (r_lo_exp == 8'd0) ? 6'd0 : 6'd1;
            end
            frwc_pkg::CMD_INIT_A: begin
                r_ss  <= 1'b0;
                r_tgt <= r_lo_exp;
                r_idx <= 9'd0;
                r_sh  <= 6'd0;
            end
            frwc_pkg::CMD_INIT_B: begin
                r_ss  <= 1'b0;
                r_tgt <= r_hi_exp;
                r_idx <= 9'd0;
                r_sh  <= 6'd0;
            end
            frwc_pkg::CMD_STEP: begin
                r_groups <= r_groups + (64'd1 << r_sh);
                r_idx    <= r_idx + 9'd1;
                if (dbl) begin
                    r_sh <= r_sh + 6'd1;
                end
            end
            frwc_pkg::CMD_ACC_LO, frwc_pkg::CMD_ACC_HI,
            frwc_pkg::CMD_ACC_EQ, frwc_pkg::CMD_ACC_TAIL: begin
                r_groups <= acc_groups;
                r_rem    <= low_sum[22:0];
            end
            frwc_pkg::CMD_ROUND: begin
                r_groups <= r_groups + {63'd0, (r_rem != 23'd0)};
            end
            frwc_pkg::CMD_CLASS: begin
                if (r_groups < frwc_pkg::LIMIT32) begin
                    r_status <= frwc_pkg::ST_U32;
                end else if (r_groups < frwc_pkg::LIMIT64) begin
                    r_status <= frwc_pkg::ST_U64;
                end else begin
                    r_status <= frwc_pkg::ST_LONG;
                end
            end
            frwc_pkg::CMD_LONG: begin
                r_status <= frwc_pkg::ST_LONG;
            end
            frwc_pkg::CMD_ORDER: begin
                r_status <= frwc_pkg::ST_ORDER;
            end
            default: begin
            end
        endcase
    end

    assign o_stat.order     = r_order;
    assign o_stat.mixed     = r_mixed;
    assign o_stat.exp_eq    = r_lo_exp == r_hi_exp;
    assign o_stat.loop_done = r_idx >= {1'b0, r_tgt};
    assign o_stat.ovf       = dbl && (r_sh == 6'd63);
    assign o_status         = r_status;

endmodule

// ===== rtl/frwc_ctrl.sv =====
// Controller state machine that sequences the exponent loops and fraction folding.
module frwc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  frwc_pkg::t_dp_stat i_stat,
    output frwc_pkg::t_cmd     o_cmd,
    output logic               o_busy,
    output logic               o_done
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SS_LOOP,
        S_SS_TAIL,
        S_A_LOOP,
        S_B_INIT,
        S_B_LOOP,
        S_ROUND,
        S_CLASS
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    logic   n_busy;
    logic   r_done;
    logic   n_done;

    always_comb begin
        n_state = r_state;
        n_busy  = r_busy;
        n_done  = 1'b0;
        o_cmd   = frwc_pkg::CMD_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd   = frwc_pkg::CMD_LOAD;
                    n_busy  = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                priority if (i_stat.order) begin
                    o_cmd   = frwc_pkg::CMD_ORDER;
                    n_done  = 1'b1;
                    n_busy  = 1'b0;
                    n_state = S_IDLE;
                end else if (i_stat.mixed) begin
                    o_cmd   = frwc_pkg::CMD_INIT_A;
                    n_state = S_A_LOOP;
                end else begin
                    o_cmd   = frwc_pkg::CMD_INIT_SS;
                    n_state = S_SS_LOOP;
                end
            end
            S_SS_LOOP: begin
                priority if (i_stat.loop_done) begin
                    o_cmd   = i_stat.exp_eq ? frwc_pkg::CMD_ACC_EQ : frwc_pkg::CMD_ACC_HI;
                    n_state = i_stat.exp_eq ? S_ROUND : S_SS_TAIL;
                end else if (i_stat.ovf) begin
                    o_cmd   = frwc_pkg::CMD_LONG;
                    n_done  = 1'b1;
                    n_busy  = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    o_cmd = frwc_pkg::CMD_STEP;
                end
            end
            S_SS_TAIL: begin
                o_cmd   = frwc_pkg::CMD_ACC_TAIL;
                n_state = S_ROUND;
            end
            S_A_LOOP: begin
                priority if (i_stat.loop_done) begin
                    o_cmd   = frwc_pkg::CMD_ACC_LO;
                    n_state = S_B_INIT;
                end else if (i_stat.ovf) begin
                    o_cmd   = frwc_pkg::CMD_LONG;
                    n_done  = 1'b1;
                    n_busy  = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    o_cmd = frwc_pkg::CMD_STEP;
                end
            end
            S_B_INIT: begin
                o_cmd   = frwc_pkg::CMD_INIT_B;
                n_state = S_B_LOOP;
            end
            S_B_LOOP: begin
                priority if (i_stat.loop_done) begin
                    o_cmd   = frwc_pkg::CMD_ACC_HI;
                    n_state = S_ROUND;
                end else if (i_stat.ovf) begin
                    o_cmd   = frwc_pkg::CMD_LONG;
                    n_done  = 1'b1;
                    n_busy  = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    o_cmd = frwc_pkg::CMD_STEP;
                end
            end
            S_ROUND: begin
                o_cmd   = frwc_pkg::CMD_ROUND;
                n_state = S_CLASS;
            end
            S_CLASS: begin
                o_cmd   = frwc_pkg::CMD_CLASS;
                n_done  = 1'b1;
                n_busy  = 1'b0;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
            r_done  <= n_done;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;

endmodule

// ===== rtl/float_range_width_class_top.sv =====
// Top level of the float range width classifier: controller plus datapath.
//
// An item (min and max float bit patterns) is taken when start is high and busy is low.
// At the end of an item busy drops and o_done pulses for one cycle with o_status, and the
// result must be captured in that cycle because it cannot be held off. An item ends at once
// with the order status when min is greater than max. Otherwise the exponent loop is walked
// once for equal signs and twice for mixed signs, and then the groups are rounded and
// classified. The exponent loop, one weight step per cycle, ends the item with the long
// status once the group weight would overflow its 64-bit accumulator. A new item may be
// accepted in the same cycle as o_done.
module float_range_width_class_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_min_bits,
    input  logic [31:0] i_max_bits,
    output logic        o_done,
    output logic [1:0]  o_status
);

    frwc_pkg::t_cmd     cmd;
    frwc_pkg::t_dp_stat stat;

    frwc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    frwc_datapath u_dp (
        .i_clk      (i_clk),
        .i_cmd      (cmd),
        .i_min_bits (i_min_bits),
        .i_max_bits (i_max_bits),
        .o_stat     (stat),
        .o_status   (o_status)
    );

endmodule

// ===== rtl/frwc_checker.sv =====
// Port-level checker for the float range width classifier and its bind to the top level.
module frwc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [1:0]  o_status
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after an item was accepted");

    a_no_instant_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> !o_done)
        else $error("result strobe came in the cycle right after acceptance");

    a_done_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy && $past(busy))
        else $error("result strobe without a preceding busy period");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe lasted more than one cycle");

    a_status_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !$isunknown(o_status))
        else $error("status is unknown while the result strobe is high");

endmodule

bind float_range_width_class_top frwc_checker u_frwc_checker (.*);
